// ----- hdl/srp_pkg.sv -----
`timescale 1ns / 1ps
package srp_pkg;

  localparam int unsigned MS_PER_S    = 1000;
  localparam int unsigned STEP_TOL_Q8 = 256;
  localparam int unsigned Q17_ONE     = 131072;

  typedef logic signed [63:0] s64_t;

  localparam s64_t MAX40 = 64'sh0000_007F_FFFF_FFFF;
  localparam s64_t MIN40 = -MAX40 - 64'sd1;
  localparam s64_t MAX48 = 64'sh0000_7FFF_FFFF_FFFF;
  localparam s64_t MIN48 = -MAX48 - 64'sd1;
  localparam s64_t MAX64 = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam s64_t MIN64 = -MAX64 - 64'sd1;

  typedef enum logic [2:0] {
    CFG_START_SPEED = 3'd0,
    CFG_ACCEL_FRAC  = 3'd1,
    CFG_DECEL_FRAC  = 3'd2,
    CFG_UM_PER_STEP = 3'd3,
    CFG_MIN_TIME    = 3'd4,
    CFG_MIN_SPEED   = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_TIME  = 2'd1,
    ERR_SPEED = 2'd2,
    ERR_RAMP  = 2'd3
  } err_t;

  typedef struct packed {
    logic [19:0] start_speed;
    logic [15:0] accel_frac;
    logic [15:0] decel_frac;
    logic [15:0] um_per_step;
    logic [15:0] min_time;
    logic [19:0] min_speed;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    start_speed: 20'd0,
    accel_frac:  16'd16384,
    decel_frac:  16'd16384,
    um_per_step: 16'd27904,
    min_time:    16'd100,
    min_speed:   20'd1
  };

  typedef struct packed {
    logic [15:0] feed_time;
    logic [19:0] feed_speed;
    logic [23:0] feed_dist;
    err_t        err;
  } item_t;

  typedef enum logic {
    ALU_MUL = 1'b0,
    ALU_DIV = 1'b1
  } alu_op_t;

  typedef struct packed {
    alu_op_t op;
    s64_t    a;
    s64_t    b;
  } alu_req_t;

  // shift right, rounding toward zero
  function automatic s64_t tz_shr(input s64_t x, input int unsigned sh);
    logic [63:0] m;
    m = x[63] ? 64'(-x) : 64'(x);
    m = m >> sh;
    return x[63] ? -s64_t'(m) : s64_t'(m);
  endfunction

  // ms to Q16 seconds: (ms << 16) / 1000 == (ms << 13) / 125, by reciprocal multiply
  function automatic s64_t ms_to_q16(input logic [15:0] ms);
    logic [58:0] p;
    p = {ms, 13'd0} * 30'd549755814;
    return s64_t'({5'd0, p[58:36]});
  endfunction

  function automatic s64_t sat_add(input s64_t a, input s64_t b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return a[63] ? MIN64 : MAX64;
    return s[63:0];
  endfunction

  function automatic logic signed [39:0] sat40(input s64_t x);
    s64_t r;
    r = x;
    if (x > MAX40) r = MAX40;
    if (x < MIN40) r = MIN40;
    return r[39:0];
  endfunction

  function automatic logic signed [47:0] sat48(input s64_t x);
    s64_t r;
    r = x;
    if (x > MAX48) r = MAX48;
    if (x < MIN48) r = MIN48;
    return r[47:0];
  endfunction

endpackage

// ----- hdl/srp_front.sv -----
`timescale 1ns / 1ps
module srp_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  logic [2:0]     cfg_index,
  input  logic [19:0]    cfg_wdata,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [15:0]    in_feed_time_ms,
  input  logic [19:0]    in_feed_speed_um_s,
  input  logic [23:0]    in_feed_distance_um,
  input  logic           q_full,
  output logic           q_push,
  output srp_pkg::item_t q_item,
  output srp_pkg::cfg_t  cfg
);
  import srp_pkg::*;

  cfg_t cfg_r;
  err_t err_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_START_SPEED: cfg_r.start_speed <= cfg_wdata;
        CFG_ACCEL_FRAC:  cfg_r.accel_frac  <= cfg_wdata[15:0];
        CFG_DECEL_FRAC:  cfg_r.decel_frac  <= cfg_wdata[15:0];
        CFG_UM_PER_STEP: cfg_r.um_per_step <= cfg_wdata[15:0];
        CFG_MIN_TIME:    cfg_r.min_time    <= cfg_wdata[15:0];
        CFG_MIN_SPEED:   cfg_r.min_speed   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // early rejects, in priority order
  always_comb begin
    if (in_feed_time_ms < cfg_r.min_time) begin
      err_w = ERR_TIME;
    end else if (in_feed_speed_um_s < cfg_r.min_speed) begin
      err_w = ERR_SPEED;
    end else if (cfg_r.um_per_step == 16'd0) begin
      err_w = ERR_RAMP;
    end else begin
      err_w = ERR_NONE;
    end
  end

  assign in_stall            = q_full;
  assign q_push              = in_valid && !q_full;
  assign q_item.feed_time    = in_feed_time_ms;
  assign q_item.feed_speed   = in_feed_speed_um_s;
  assign q_item.feed_dist    = in_feed_distance_um;
  assign q_item.err          = err_w;
  assign cfg                 = cfg_r;

endmodule

// ----- hdl/srp_queue.sv -----
`timescale 1ns / 1ps
module srp_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  srp_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output srp_pkg::item_t head
);
  import srp_pkg::*;

  item_t      mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign head  = mem_r[rd_ptr_r];

endmodule

// ----- hdl/srp_alu.sv -----
`timescale 1ns / 1ps
module srp_alu (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  srp_pkg::alu_req_t req,
  output logic              busy,
  output logic              done,
  output srp_pkg::s64_t     result
);
  import srp_pkg::*;

  typedef enum logic [1:0] {
    A_IDLE = 2'b01,
    A_RUN  = 2'b10
  } alu_state_t;

  alu_state_t  state_r, state_nxt;
  alu_op_t     op_r;
  logic        neg_r;
  logic [5:0]  cnt_r;
  logic [63:0] x_r;
  logic [63:0] y_r;
  logic [95:0] acc_r;
  logic        done_r;
  s64_t        res_r;
  logic [63:0] mag_a;
  logic [63:0] mag_b;
  logic [95:0] mul_acc;
  logic [64:0] rem_sh;
  logic [65:0] rem_sub;
  logic        div_bit;
  logic [63:0] quo;
  s64_t        res_w;

  assign mag_a = req.a[63] ? 64'(-req.a) : 64'(req.a);
  assign mag_b = req.b[63] ? 64'(-req.b) : 64'(req.b);

  // multiply: shift-add over the 32 low bits of |a|; divide: restoring, one bit a cycle
  always_comb begin
    mul_acc = {acc_r[94:0], 1'b0} + (x_r[63] ? {32'd0, y_r} : 96'd0);
    rem_sh  = {acc_r[63:0], x_r[63]};
    rem_sub = {1'b0, rem_sh} - {2'b00, y_r};
    div_bit = ~rem_sub[65];
    quo     = {x_r[62:0], div_bit};
    if (op_r == ALU_MUL) begin
      if (mul_acc[95:63] != 33'd0) begin
        res_w = neg_r ? MIN64 : MAX64;
      end else begin
        res_w = neg_r ? -s64_t'(mul_acc[63:0]) : s64_t'(mul_acc[63:0]);
      end
    end else begin
      res_w = neg_r ? -s64_t'(quo) : s64_t'(quo);
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      A_IDLE: if (start) state_nxt = A_RUN;
      A_RUN:  if (cnt_r == 6'd0) state_nxt = A_IDLE;
      default: state_nxt = A_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == A_RUN) && (cnt_r == 6'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == A_IDLE && start) begin
      op_r  <= req.op;
      neg_r <= req.a[63] ^ req.b[63];
      y_r   <= mag_b;
      acc_r <= '0;
      if (req.op == ALU_MUL) begin
        x_r   <= {mag_a[31:0], 32'd0};
        cnt_r <= 6'd31;
      end else begin
        x_r   <= mag_a;
        cnt_r <= 6'd63;
      end
    end else if (state_r == A_RUN) begin
      cnt_r <= cnt_r - 6'd1;
      if (op_r == ALU_MUL) begin
        acc_r <= mul_acc;
        x_r   <= {x_r[62:0], 1'b0};
      end else begin
        acc_r <= {32'd0, div_bit ? rem_sub[63:0] : rem_sh[63:0]};
        x_r   <= quo;
      end
      if (cnt_r == 6'd0) res_r <= res_w;
    end
  end

  assign busy   = (state_r != A_IDLE);
  assign done   = done_r;
  assign result = res_r;

endmodule

// ----- hdl/srp_back.sv -----
`timescale 1ns / 1ps
module srp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  srp_pkg::cfg_t       cfg,
  input  logic                q_empty,
  input  srp_pkg::item_t      q_head,
  output logic                q_pop,
  output logic                alu_start,
  output srp_pkg::alu_req_t   alu_req,
  input  logic                alu_busy,
  input  logic                alu_done,
  input  srp_pkg::s64_t       alu_result,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_error_code,
  output logic signed [39:0]  out_peak_speed,
  output logic signed [39:0]  out_target_steps,
  output logic signed [47:0]  out_start_accel,
  output logic signed [47:0]  out_main_accel,
  output logic signed [47:0]  out_stop_decel,
  output logic signed [47:0]  out_main_decel
);
  import srp_pkg::*;

  typedef enum logic [3:0] {
    B_IDLE  = 4'b0001,
    B_ISSUE = 4'b0010,
    B_WAIT  = 4'b0100,
    B_HOLD  = 4'b1000
  } back_state_t;

  typedef enum logic [4:0] {
    S_DT1, S_DT3, S_C1, S_C2, S_V1Q, S_VQ, S_DQ,
    S_PK1, S_PK2, S_PEAK, S_TR0, S_TR1, S_TR2, S_TR3,
    S_SACC, S_MACC, S_MDEC
  } step_t;

  back_state_t       state_r;
  step_t             step_r;
  item_t             item_r;
  err_t              err_r;
  s64_t              t16_r, t0_r, m16_r, dt1_r, dt2_r, dt3_r, c1_r, c2_r;
  s64_t              v1q_r, vq_r, dq_r, tmp_r, dv_r, tot2_r, target_r;
  s64_t              sacc_r, macc_r, mdec_r;
  logic signed [39:0] peak_r;
  logic              out_valid_r;
  logic [1:0]        out_err_r;
  logic signed [39:0] out_peak_r, out_target_r;
  logic signed [47:0] out_sacc_r, out_macc_r, out_sdec_r, out_mdec_r;

  logic [16:0]       frac_sum;
  logic [17:0]       frac_rest;
  s64_t              t16_w;
  s64_t              t0_w;
  s64_t              sum_w;
  s64_t              target_w;
  s64_t              diff_w;
  s64_t              c2_w;
  s64_t              dt3_w;
  logic signed [39:0] peak_w;
  logic              bad_w;
  logic              out_free;

  assign frac_sum  = {1'b0, cfg.accel_frac} + {1'b0, cfg.decel_frac};
  assign frac_rest = 18'(Q17_ONE) - {1'b0, frac_sum};
  assign out_free  = !out_valid_r || !out_stall;
  assign t16_w     = ms_to_q16(q_head.feed_time);
  assign t0_w      = ms_to_q16(cfg.min_time);

  // operands for the current step
  always_comb begin
    alu_req.op = ALU_MUL;
    alu_req.a  = '0;
    alu_req.b  = '0;
    case (step_r)
      S_DT1: begin
        alu_req.a = 64'(cfg.accel_frac);
        alu_req.b = m16_r;
      end
      S_DT3: begin
        alu_req.a = 64'(cfg.decel_frac);
        alu_req.b = m16_r;
      end
      S_C1: begin
        alu_req.a = 64'(frac_sum);
        alu_req.b = m16_r;
      end
      S_C2: begin
        alu_req.a = 64'(frac_rest);
        alu_req.b = m16_r;
      end
      S_V1Q: begin
        alu_req.op = ALU_DIV;
        alu_req.a  = 64'({cfg.start_speed, 16'd0});
        alu_req.b  = 64'(cfg.um_per_step);
      end
      S_VQ: begin
        alu_req.op = ALU_DIV;
        alu_req.a  = 64'({item_r.feed_speed, 16'd0});
        alu_req.b  = 64'(cfg.um_per_step);
      end
      S_DQ: begin
        alu_req.op = ALU_DIV;
        alu_req.a  = 64'({item_r.feed_dist, 16'd0});
        alu_req.b  = 64'(cfg.um_per_step);
      end
      S_PK1: begin
        alu_req.a = t16_r;
        alu_req.b = vq_r;
      end
      S_PK2: begin
        alu_req.a = c1_r;
        alu_req.b = v1q_r;
      end
      S_PEAK: begin
        alu_req.op = ALU_DIV;
        alu_req.a  = tmp_r;
        alu_req.b  = c2_r;
      end
      S_TR0: begin
        alu_req.a = t0_r <<< 1;
        alu_req.b = v1q_r;
      end
      S_TR1: begin
        alu_req.a = dt1_r + dt3_r;
        alu_req.b = dv_r;
      end
      S_TR2: begin
        alu_req.a = dt2_r <<< 1;
        alu_req.b = dv_r;
      end
      S_TR3: begin
        alu_req.a = (dt1_r + dt2_r + dt3_r) <<< 1;
        alu_req.b = v1q_r;
      end
      S_SACC: begin
        alu_req.op = ALU_DIV;
        alu_req.a  = v1q_r <<< 16;
        alu_req.b  = t0_r;
      end
      S_MACC: begin
        alu_req.op = ALU_DIV;
        alu_req.a  = dv_r <<< 16;
        alu_req.b  = dt1_r;
      end
      S_MDEC: begin
        alu_req.op = ALU_DIV;
        alu_req.a  = -(dv_r <<< 16);
        alu_req.b  = dt3_r;
      end
      default: ;
    endcase
  end

  // checks on the step that just finished
  always_comb begin
    sum_w    = sat_add(tot2_r, alu_result);
    target_w = tz_shr(sum_w, 17);
    diff_w   = target_w - dq_r;
    c2_w     = tz_shr(alu_result, 17);
    dt3_w    = tz_shr(alu_result, 16);
    peak_w   = sat40(alu_result);
    bad_w    = 1'b0;
    if (step_r == S_C2) begin
      bad_w = (c2_w == 64'sd0);
    end else if (step_r == S_TR3) begin
      bad_w = (diff_w >= s64_t'(STEP_TOL_Q8)) || (diff_w <= -s64_t'(STEP_TOL_Q8)) ||
              (t0_r == 64'sd0) || (dt1_r == 64'sd0) || (dt3_r == 64'sd0);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == B_IDLE && !q_empty) begin
      t16_r <= t16_w;
      t0_r  <= t0_w;
      m16_r <= t16_w - (t0_w <<< 1);
    end else if (state_r == B_WAIT && alu_done) begin
      case (step_r)
        S_DT1: dt1_r <= tz_shr(alu_result, 16);
        S_DT3: begin
          dt3_r <= dt3_w;
          dt2_r <= t16_r - ((t0_r <<< 1) + dt1_r + dt3_w);
        end
        S_C1:  c1_r  <= (t0_r <<< 1) + tz_shr(alu_result, 17);
        S_C2:  c2_r  <= c2_w;
        S_V1Q: v1q_r <= alu_result;
        S_VQ:  vq_r  <= alu_result;
        S_DQ:  dq_r  <= alu_result;
        S_PK1: tmp_r <= alu_result;
        S_PK2: tmp_r <= tmp_r - alu_result;
        S_PEAK: begin
          peak_r <= peak_w;
          dv_r   <= 64'(peak_w) - v1q_r;
        end
        S_TR0: tot2_r <= alu_result;
        S_TR1, S_TR2: tot2_r <= sum_w;
        S_TR3: begin
          tot2_r   <= sum_w;
          target_r <= target_w;
        end
        S_SACC: sacc_r <= alu_result;
        S_MACC: macc_r <= alu_result;
        S_MDEC: mdec_r <= alu_result;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == B_IDLE && !q_empty) begin
      item_r <= q_head;
    end
    if (out_free && state_r == B_HOLD) begin
      out_err_r <= err_r;
      if (err_r == ERR_NONE) begin
        out_peak_r   <= peak_r;
        out_target_r <= sat40(target_r);
        out_sacc_r   <= sat48(sacc_r);
        out_macc_r   <= sat48(macc_r);
        out_sdec_r   <= sat48(-sacc_r);
        out_mdec_r   <= sat48(mdec_r);
      end else begin
        out_peak_r   <= '0;
        out_target_r <= '0;
        out_sacc_r   <= '0;
        out_macc_r   <= '0;
        out_sdec_r   <= '0;
        out_mdec_r   <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      step_r      <= S_DT1;
      err_r       <= ERR_NONE;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == B_HOLD && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        B_IDLE: begin
          if (!q_empty) begin
            err_r  <= q_head.err;
            step_r <= S_DT1;
            state_r <= (q_head.err == ERR_NONE) ? B_ISSUE : B_HOLD;
          end
        end
        B_ISSUE: state_r <= B_WAIT;
        B_WAIT: begin
          if (alu_done) begin
            if (bad_w) begin
              err_r   <= ERR_RAMP;
              state_r <= B_HOLD;
            end else if (step_r == S_MDEC) begin
              state_r <= B_HOLD;
            end else begin
              step_r  <= step_t'(step_r + 5'd1);
              state_r <= B_ISSUE;
            end
          end
        end
        B_HOLD: begin
          if (out_free) begin
            state_r <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  assign q_pop            = (state_r == B_IDLE) && !q_empty;
  assign alu_start        = (state_r == B_ISSUE);
  assign out_valid        = out_valid_r;
  assign out_error_code   = out_err_r;
  assign out_peak_speed   = out_peak_r;
  assign out_target_steps = out_target_r;
  assign out_start_accel  = out_sacc_r;
  assign out_main_accel   = out_macc_r;
  assign out_stop_decel   = out_sdec_r;
  assign out_main_decel   = out_mdec_r;

  a_alu_free: assert property (@(posedge clk) disable iff (!rst_n)
    alu_start |-> !alu_busy)
    else $error("alu started while busy");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    alu_start && alu_req.op == ALU_DIV |-> alu_req.b != 64'sd0)
    else $error("division issued with zero divisor");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_err_r != ERR_NONE |->
      out_peak_r == '0 && out_target_r == '0 && out_sacc_r == '0 &&
      out_macc_r == '0 && out_sdec_r == '0 && out_mdec_r == '0)
    else $error("error result carries nonzero fields");

endmodule

// ----- hdl/stepper_ramp_parameter_calc_top.sv -----
`timescale 1ns / 1ps
// ramp planner for a six-point stepper velocity profile: each request (feed time in ms,
// mean speed in um/s, distance in um) returns error code, peak speed, travel in steps and
// the four accelerations, all signed Q8. requests are checked and queued (two entries) by
// the front; the back converts the times to Q16 seconds with a reciprocal multiply, then
// runs a sequence of 10 multiplies and 7 divides on one shared bit-serial multiply/divide
// unit, ending early if a ramp check fails. the result sits in an output register, so the
// next request is taken while the previous result waits. configuration is written through
// cfg_we / cfg_index / cfg_wdata; the user must write it only while no request is in
// flight, as the block itself does not enforce it.
module stepper_ramp_parameter_calc_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [19:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        in_feed_time_ms,
  input  logic [19:0]        in_feed_speed_um_s,
  input  logic [23:0]        in_feed_distance_um,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_error_code,
  output logic signed [39:0] out_peak_speed,
  output logic signed [39:0] out_target_steps,
  output logic signed [47:0] out_start_accel,
  output logic signed [47:0] out_main_accel,
  output logic signed [47:0] out_stop_decel,
  output logic signed [47:0] out_main_decel
);
  import srp_pkg::*;

  cfg_t     cfg;
  item_t    push_item;
  item_t    head;
  logic     q_push, q_full, q_pop, q_empty;
  logic     alu_start, alu_busy, alu_done;
  alu_req_t alu_req;
  s64_t     alu_result;

  srp_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_feed_time_ms     (in_feed_time_ms),
    .in_feed_speed_um_s  (in_feed_speed_um_s),
    .in_feed_distance_um (in_feed_distance_um),
    .q_full              (q_full),
    .q_push              (q_push),
    .q_item              (push_item),
    .cfg                 (cfg)
  );

  srp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (head)
  );

  srp_alu u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (alu_start),
    .req    (alu_req),
    .busy   (alu_busy),
    .done   (alu_done),
    .result (alu_result)
  );

  srp_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .q_empty          (q_empty),
    .q_head           (head),
    .q_pop            (q_pop),
    .alu_start        (alu_start),
    .alu_req          (alu_req),
    .alu_busy         (alu_busy),
    .alu_done         (alu_done),
    .alu_result       (alu_result),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_error_code   (out_error_code),
    .out_peak_speed   (out_peak_speed),
    .out_target_steps (out_target_steps),
    .out_start_accel  (out_start_accel),
    .out_main_accel   (out_main_accel),
    .out_stop_decel   (out_stop_decel),
    .out_main_decel   (out_main_decel)
  );

endmodule
